// File: rtl/pcmppe_pkg.sv
package pcmppe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CODE_W   = 10;
  localparam int MIN_W    = 16;
  localparam int PULSE_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_16BIT = 2'd1;

  typedef enum logic {
    CMD_PAIR = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       packet_last;
  } in_beat_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic               from_buffer;
  } out_beat_t;

  function automatic logic [CODE_W-1:0] pair_to_code(
    input logic [SAMPLE_W-1:0] l,
    input logic [SAMPLE_W-1:0] r
  );
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] ro;
    logic [SAMPLE_W-1:0] sum;
    lo  = {~l[SAMPLE_W-1], l[SAMPLE_W-2:0]};
    ro  = {~r[SAMPLE_W-1], r[SAMPLE_W-2:0]};
    sum = (lo >> 1) + (ro >> 1);
    return sum[SAMPLE_W-1:SAMPLE_W-CODE_W];
  endfunction

endpackage

// File: rtl/pcmppe_ram.sv
module pcmppe_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pcm_to_ppm_ping_pong_emitter_core.sv
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------
// in       | in_valid / in_stall | in_data  : cmd, left/right sample, last
// out      | out_valid/out_stall | out_data : pulse_width, from_buffer
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (write only)
//
// One beat per cycle sustained on the input while in_stall is low; a tick's
// result passes through the registered read of the code RAM and then the
// output register.
// Reset (synchronous, rst_n low) empties both halves and the pipeline; the
// code RAM is not cleared, only written entries are ever used.
// A stalled output holds its beat; one more tick may wait behind it, after
// that in_stall rises until the output drains.
module pcm_to_ppm_ping_pong_emitter_core
  import pcmppe_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64,
  localparam int PW = $clog2(BUFFER_DEPTH + 1),
  localparam int AW = $clog2(2 * BUFFER_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [AW-1:0] HALF_BASE = AW'(BUFFER_DEPTH);
  localparam logic [PW-1:0] DEPTH_P   = PW'(BUFFER_DEPTH);

  logic [MIN_W-1:0] min_interval_r;
  logic             format_16bit_r;

  logic [1:0]       ready_r;
  logic [PW-1:0]    fill_r [2];
  logic             wside_r;
  logic             rside_r;
  logic [PW-1:0]    wpos_r;
  logic [PW-1:0]    rpos_r;
  logic             in_packet_r;
  logic             drop_r;

  logic             s1_v_r;
  logic             s1_from_r;
  logic [MIN_W-1:0] s1_min_r;
  logic             out_v_r;
  out_beat_t        out_r;

  logic             move;
  logic             accept;
  logic             acc_pair;
  logic             acc_tick;
  logic             drop_eff;
  logic [PW-1:0]    pos_eff;
  logic             store;
  logic [PW-1:0]    new_pos;
  logic             hit;
  logic [PW-1:0]    rpos_inc;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [CODE_W-1:0] wcode;
  logic [CODE_W-1:0] rdata;
  logic [PULSE_W-1:0] pulse_sum;

  assign cfg_ready = 1'b1;
  assign move      = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !move;
  assign accept    = in_valid && !in_stall;
  assign acc_pair  = accept && (in_data.cmd == CMD_PAIR);
  assign acc_tick  = accept && (in_data.cmd == CMD_TICK);

  assign drop_eff = in_packet_r ? drop_r : (ready_r[wside_r] || !format_16bit_r);
  assign pos_eff  = in_packet_r ? wpos_r : '0;
  assign store    = !drop_eff && (pos_eff < DEPTH_P);
  assign new_pos  = pos_eff + PW'(store);
  assign waddr    = wside_r ? (HALF_BASE + AW'(pos_eff)) : AW'(pos_eff);
  assign wcode    = pair_to_code(in_data.left_sample, in_data.right_sample);

  assign hit      = ready_r[rside_r];
  assign rpos_inc = rpos_r + PW'(1);
  assign raddr    = rside_r ? (HALF_BASE + AW'(rpos_r)) : AW'(rpos_r);

  pcmppe_ram #(
    .WIDTH(CODE_W),
    .DEPTH(2 * BUFFER_DEPTH)
  ) u_code_ram (
    .clk  (clk),
    .we   (acc_pair && store),
    .waddr(waddr),
    .wdata(wcode),
    .re   (acc_tick),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign pulse_sum = {1'b0, s1_min_r}
                   + (s1_from_r ? {{(PULSE_W-CODE_W){1'b0}}, rdata} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= '0;
      format_16bit_r <= 1'b0;
      ready_r        <= '0;
      fill_r[0]      <= '0;
      fill_r[1]      <= '0;
      wside_r        <= 1'b0;
      rside_r        <= 1'b0;
      wpos_r         <= '0;
      rpos_r         <= '0;
      in_packet_r    <= 1'b0;
      drop_r         <= 1'b0;
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_INTERVAL: min_interval_r <= cfg_data[MIN_W-1:0];
          REG_FORMAT_16BIT: format_16bit_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (acc_pair) begin
        if (in_data.packet_last) begin
          if (!drop_eff) begin
            fill_r[wside_r]  <= new_pos;
            ready_r[wside_r] <= 1'b1;
            wside_r          <= ~wside_r;
          end
          in_packet_r <= 1'b0;
          drop_r      <= 1'b0;
          wpos_r      <= '0;
        end else begin
          in_packet_r <= 1'b1;
          drop_r      <= drop_eff;
          wpos_r      <= new_pos;
        end
      end

      if (acc_tick && hit) begin
        if (rpos_inc >= fill_r[rside_r]) begin
          ready_r[rside_r] <= 1'b0;
          fill_r[rside_r]  <= '0;
          rpos_r           <= '0;
          rside_r          <= ~rside_r;
        end else begin
          rpos_r <= rpos_inc;
        end
      end

      if (acc_tick) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end

      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_tick) begin
      s1_from_r <= hit;
      s1_min_r  <= min_interval_r;
    end
    if (move) begin
      out_r.pulse_width <= pulse_sum;
      out_r.from_buffer <= s1_from_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: rtl/pcmppe_checker.sv
module pcmppe_checker
  import pcmppe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  logic tick_beat;
  assign tick_beat = in_valid && !in_stall && (in_data.cmd == CMD_TICK);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_filler_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.from_buffer |-> !out_data.pulse_width[PULSE_W-1])
    else $error("filler pulse exceeds base interval range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_beat |-> ##2 out_valid)
    else $error("tick beat produced no output");

endmodule

bind pcm_to_ppm_ping_pong_emitter_core pcmppe_checker u_pcmppe_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// File: tb/pcmppe_pulse_checker.sv
module pcmppe_pulse_checker
  import pcmppe_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_beat_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_beat_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  logic [CODE_W-1:0] codes [2*BUFFER_DEPTH];
  logic              ready_half [2];
  logic [PW-1:0]     fill_half [2];
  logic              wr_half;
  logic              rd_half;
  logic [PW-1:0]     wr_pos;
  logic [PW-1:0]     rd_pos;
  logic              open_pkt;
  logic              skip_pkt;
  logic [MIN_W-1:0]  base_gap;
  logic              fmt16;
  out_beat_t         pulses [$];
  out_beat_t         want;
  out_beat_t         got;

  task automatic store_pair(input in_beat_t b);
    logic signed [SAMPLE_W:0] mix;
    logic [SAMPLE_W:0]        biased;
    if (!open_pkt) begin
      open_pkt = 1'b1;
      skip_pkt = ready_half[wr_half] || !fmt16;
      wr_pos = '0;
    end
    if (!skip_pkt && wr_pos < BUFFER_DEPTH) begin
      mix = ($signed({b.left_sample[SAMPLE_W-1], b.left_sample}) >>> 1)
          + ($signed({b.right_sample[SAMPLE_W-1], b.right_sample}) >>> 1);
      biased = mix + 17'd32768;
      codes[wr_half*BUFFER_DEPTH + wr_pos] = biased[SAMPLE_W-1:SAMPLE_W-CODE_W];
      wr_pos = wr_pos + 1'b1;
    end
    if (b.packet_last) begin
      if (!skip_pkt) begin
        fill_half[wr_half] = wr_pos;
        ready_half[wr_half] = 1'b1;
        wr_half = !wr_half;
      end
      open_pkt = 1'b0;
      skip_pkt = 1'b0;
      wr_pos = '0;
    end
  endtask

  task automatic next_pulse(output out_beat_t p);
    p.pulse_width = base_gap;
    p.from_buffer = 1'b0;
    if (ready_half[rd_half] && rd_pos < fill_half[rd_half] && rd_pos < BUFFER_DEPTH) begin
      p.pulse_width = base_gap + codes[rd_half*BUFFER_DEPTH + rd_pos];
      p.from_buffer = 1'b1;
      rd_pos = rd_pos + 1'b1;
      if (rd_pos >= fill_half[rd_half]) begin
        ready_half[rd_half] = 1'b0;
        fill_half[rd_half] = '0;
        rd_pos = '0;
        rd_half = !rd_half;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_half[0] = 1'b0;
      ready_half[1] = 1'b0;
      fill_half[0] = '0;
      fill_half[1] = '0;
      wr_half = 1'b0;
      rd_half = 1'b0;
      wr_pos = '0;
      rd_pos = '0;
      open_pkt = 1'b0;
      skip_pkt = 1'b0;
      base_gap = '0;
      fmt16 = 1'b0;
      errors = 0;
      pulses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pulses.size() == 0) begin
          $error("pulse beat with none due: pulse_width %0d from_buffer %0d",
                 got.pulse_width, got.from_buffer);
          errors++;
        end else begin
          want = pulses.pop_front();
          if (got.pulse_width !== want.pulse_width) begin
            $error("pulse_width: expected %0d, got %0d", want.pulse_width, got.pulse_width);
            errors++;
          end
          if (got.from_buffer !== want.from_buffer) begin
            $error("from_buffer: expected %0d, got %0d", want.from_buffer, got.from_buffer);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_INTERVAL: base_gap = cfg_data[MIN_W-1:0];
          REG_FORMAT_16BIT: fmt16 = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_TICK) begin
          next_pulse(want);
          pulses.push_back(want);
        end else begin
          store_pair(in_data);
        end
      end
    end
    pending = pulses.size();
  end

endmodule

// File: tb/pcm_to_ppm_ping_pong_emitter_core_test.sv
module pcm_to_ppm_ping_pong_emitter_core_test
  import pcmppe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFER_DEPTH = 64;
  localparam int NUM_RANDOM   = 1300;
  localparam int SETTLE       = 6;
  localparam int QUIET_LIMIT  = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_beat_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    sent = 0;
  int unsigned           quiet = 0;
  bit                    in_calm = 1'b0;
  bit                    out_calm = 1'b0;

  always #4ns clk = ~clk;

  pcm_to_ppm_ping_pong_emitter_core #(.BUFFER_DEPTH(BUFFER_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pcmppe_pulse_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) pulse_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  task automatic send_beat(input in_beat_t b);
    int unsigned n;
    if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
    n = in_calm ? 0 : $urandom_range(0, 17);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                           input logic last);
    in_beat_t b;
    b.cmd = CMD_PAIR;
    b.left_sample = l;
    b.right_sample = r;
    b.packet_last = last;
    send_beat(b);
  endtask

  task automatic send_tick;
    in_beat_t b;
    b.cmd = CMD_TICK;
    b.left_sample = SAMPLE_W'($urandom);
    b.right_sample = SAMPLE_W'($urandom);
    b.packet_last = 1'($urandom_range(0, 1));
    send_beat(b);
  endtask

  // hold until every pulse is back and the pipeline is quiet
  task automatic settle;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input logic [MIN_W-1:0] gap, input logic fmt);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MIN_INTERVAL;
    cfg_data <= gap;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FORMAT_16BIT;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, fmt};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : out_side
    int unsigned n;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      n = out_calm ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int              start;
    int              phase_end;
    int unsigned     choice;
    int unsigned     len;
    int unsigned     k;
    logic [MIN_W-1:0] gap;
    in_beat_t        b;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // format off after reset: packet dropped, ticks idle
    send_tick();
    send_pair(16'h7fff, 16'h7fff, 1'b0);
    send_pair(16'hffff, 16'h0000, 1'b1);
    send_tick();
    settle();
    set_regs(16'hffff, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'h7fff, 16'h7fff, 1'b0);
    send_pair(16'h8000, 16'h7fff, 1'b0);
    send_pair(16'hffff, 16'h0000, 1'b1);
    send_pair(16'h0001, 16'hffff, 1'b1);
    // both halves full: drop
    send_pair(16'h0005, 16'h0005, 1'b1);
    repeat (7) send_tick();
    settle();

    start = sent;
    while (sent < start + NUM_RANDOM) begin
      phase_end = sent + $urandom_range(60, 220);
      if (phase_end > start + NUM_RANDOM) phase_end = start + NUM_RANDOM;
      case ($urandom_range(0, 5))
        0: gap = '0;
        1: gap = '1;
        default: gap = MIN_W'($urandom);
      endcase
      settle();
      set_regs(gap, $urandom_range(0, 7) != 0);
      while (sent < phase_end) begin
        choice = $urandom_range(0, 9);
        if (choice < 5) begin
          len = ($urandom_range(0, 11) == 0) ?
                $urandom_range(BUFFER_DEPTH - 4, BUFFER_DEPTH + 12) : $urandom_range(1, 24);
          for (k = 1; k <= len && sent < phase_end; k++)
            send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom), k == len);
        end else if (choice < 9) begin
          len = $urandom_range(1, 40);
          for (k = 0; k < len && sent < phase_end; k++)
            send_tick();
        end else begin
          b.cmd = cmd_t'($urandom_range(0, 1));
          b.left_sample = SAMPLE_W'($urandom);
          b.right_sample = SAMPLE_W'($urandom);
          b.packet_last = 1'($urandom_range(0, 1));
          send_beat(b);
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
